// File: hw/rtl/sha512_hash_engine_assert.svh
// Assertion macros for the hash engine.
`ifndef SHA512_HASH_ENGINE_ASSERT_SVH
`define SHA512_HASH_ENGINE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SHE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/she_pkg.sv
`default_nettype none
package she_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
  } she_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
  } she_out_t;

  // Command from the front part to the compression core.
  typedef struct packed {
    logic [1023:0] block;
    logic          final_blk;
  } she_cmd_t;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam int         PAD_LIMIT   = 112;
  localparam int         BLOCK_BYTES = 128;
  localparam int         ROUNDS      = 80;
  localparam logic       MODE_512    = 1'b0;
  localparam logic       MODE_384    = 1'b1;
  localparam logic [0:0] REG_MODE    = 1'b0;

  localparam logic [63:0] ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [511:0] INIT_512 = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [511:0] INIT_384 = {
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/she_front.sv
`default_nettype none
// Packs bytes into the block buffer and issues blocks, with padding at the end.
module she_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           restart,
  input  wire logic           in_valid,
  input  wire she_pkg::she_in_t in_item,
  output logic                in_ready,
  output logic                cmd_valid,
  output she_pkg::she_cmd_t   cmd,
  input  wire logic           cmd_ready
);
  import she_pkg::*;

  typedef enum logic [1:0] {S_TAKE, S_BLOCK, S_PAD1, S_PAD2} state_t;

  state_t         state;
  logic [1023:0]  buffer;
  logic [6:0]     fill;
  logic [127:0]   bit_count;
  logic [63:0]    word;
  logic [3:0]     left;
  logic           last_pend;

  logic [3:0]     cnt_clip;
  logic [7:0]     fill_ext;
  logic [1023:0]  pad_mask;
  logic [1023:0]  pad_blk;
  logic           need_two;
  logic [9:0]     bit_pos;
  logic           issue;

  assign cnt_clip = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
  assign fill_ext = {1'b0, fill};
  assign need_two = fill_ext >= 8'(PAD_LIMIT);
  assign bit_pos  = 10'(1023 - 8 * int'(fill));
  assign issue    = (state != S_TAKE) && (!cmd_valid || cmd_ready);

  always_comb begin
    pad_mask = '1;
    pad_mask = pad_mask << (11'd1024 - {1'b0, fill, 3'b000});
    if (fill == 7'd0) pad_mask = '0;
    pad_blk = buffer & pad_mask;
    pad_blk[bit_pos -: 8] = PAD_BYTE;
  end

  assign in_ready = (state == S_TAKE) && (left == 4'd0) && !last_pend && !restart;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= S_TAKE;
      fill      <= '0;
      bit_count <= '0;
      left      <= '0;
      last_pend <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (issue) cmd_valid <= 1'b1;
      else if (cmd_ready) cmd_valid <= 1'b0;
      unique case (state)
        S_TAKE: begin
          if (in_valid && in_ready) begin
            word      <= in_item.data_word;
            left      <= cnt_clip;
            last_pend <= in_item.last_word;
            bit_count <= bit_count + 128'({cnt_clip, 3'b000});
          end else if (left != 4'd0) begin
            buffer[10'(1023 - 8 * int'(fill)) -: 8] <= word[63:56];
            word <= {word[55:0], 8'h00};
            left <= left - 4'd1;
            fill <= fill + 7'd1;
            if (fill == 7'(BLOCK_BYTES - 1)) state <= S_BLOCK;
          end else if (last_pend) begin
            state <= S_PAD1;
          end
        end
        S_BLOCK: begin
          if (issue) begin
            cmd.block     <= buffer;
            cmd.final_blk <= 1'b0;
            state         <= S_TAKE;
          end
        end
        S_PAD1: begin
          if (issue) begin
            if (need_two) begin
              cmd.block     <= pad_blk;
              cmd.final_blk <= 1'b0;
              state         <= S_PAD2;
            end else begin
              cmd.block     <= {pad_blk[1023:128], bit_count};
              cmd.final_blk <= 1'b1;
              state         <= S_TAKE;
              fill          <= '0;
              bit_count     <= '0;
              last_pend     <= 1'b0;
            end
          end
        end
        S_PAD2: begin
          if (issue) begin
            cmd.block     <= {896'd0, bit_count};
            cmd.final_blk <= 1'b1;
            state         <= S_TAKE;
            fill          <= '0;
            bit_count     <= '0;
            last_pend     <= 1'b0;
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/she_core.sv
`default_nettype none
// One SHA-512 round per cycle; emits the digest after a final block.
module she_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             restart,
  input  wire logic             mode,
  input  wire logic             cmd_valid,
  input  wire she_pkg::she_cmd_t cmd,
  output logic                  cmd_ready,
  output logic                  out_valid,
  output she_pkg::she_out_t     out_item,
  input  wire logic             out_ready
);
  import she_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD, C_EMIT} state_t;

  state_t        state;
  logic [511:0]  chain;
  logic [63:0]   v [8];
  logic [63:0]   w [16];
  logic [6:0]    rnd;
  logic          fin;
  logic [2:0]    idx;

  logic [63:0] t1, t2, s0, s1, wn;
  logic [2:0]  idx_end;

  assign idx_end = (mode == MODE_384) ? 3'd5 : 3'd7;

  always_comb begin
    t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[rnd] + w[0];
    t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
    s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
    wn = s1 + w[9] + s0 + w[0];
  end

  assign cmd_ready = (state == C_IDLE) && !restart;
  assign out_valid = (state == C_EMIT);
  assign out_item.digest_word  = chain[9'(511 - 64 * int'(idx)) -: 64];
  assign out_item.digest_index = idx;
  assign out_item.digest_last  = (idx == idx_end);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= C_IDLE;
      chain <= (mode == MODE_384) ? INIT_384 : INIT_512;
      rnd   <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= cmd.block[1023 - 64 * i -: 64];
            for (int i = 0; i < 8; i++) v[i] <= chain[511 - 64 * i -: 64];
            fin   <= cmd.final_blk;
            rnd   <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          v[0] <= t1 + t2; v[1] <= v[0]; v[2] <= v[1]; v[3] <= v[2];
          v[4] <= v[3] + t1; v[5] <= v[4]; v[6] <= v[5]; v[7] <= v[6];
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= wn;
          rnd <= rnd + 7'd1;
          if (rnd == 7'(ROUNDS - 1)) state <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++)
            chain[511 - 64 * i -: 64] <= chain[511 - 64 * i -: 64] + v[i];
          idx   <= '0;
          state <= fin ? C_EMIT : C_IDLE;
        end
        C_EMIT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == idx_end) begin
              chain <= (mode == MODE_384) ? INIT_384 : INIT_512;
              state <= C_IDLE;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/she_fifo.sv
`default_nettype none
// Two-entry result queue.
module she_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_valid,
  input  wire she_pkg::she_out_t wr_item,
  output logic                 wr_ready,
  output logic                 rd_valid,
  output she_pkg::she_out_t    rd_item,
  input  wire logic            rd_ready
);
  import she_pkg::*;

  she_out_t   mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_item;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/sha512_hash_engine.sv
`default_nettype none
// SHA-512 / SHA-384 engine. Push big-endian 64-bit message words; mark the last
// with last_word (byte_count below 8 allowed). The front takes a word and then
// packs one byte per cycle, while no full block waits to be issued, into a
// 128-byte block and pads at the end; the core compresses a block in 80 rounds
// (one per cycle, plus load and add) behind it. The front takes no new word until
// it has packed every byte of the last one. After the last word the digest
// (8 words, or 6 for SHA-384) appears on the result queue.
// Write hash_mode (address 0) only while idle; it restarts the message.
module sha512_hash_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire she_pkg::she_in_t  in_item,
  output logic                   full,
  output logic                   empty,
  output she_pkg::she_out_t      out_item,
  input  wire logic              pop,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [0:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import she_pkg::*;
`include "sha512_hash_engine_assert.svh"

  logic       hash_mode;
  logic       restart;
  logic       in_ready, cmd_valid, cmd_ready, core_valid, core_ready, rd_valid;
  she_cmd_t   cmd;
  she_out_t   core_item;

  assign pready  = 1'b1;
  assign restart = psel && penable && pwrite && (paddr == REG_MODE);
  assign prdata  = {31'd0, hash_mode};

  always_ff @(posedge clk) begin
    if (rst) hash_mode <= MODE_512;
    else if (restart) hash_mode <= pwdata[0];
  end

  assign full  = !in_ready;
  assign empty = !rd_valid;

  she_front u_front (
    .clk, .rst, .restart, .in_valid(push), .in_item, .in_ready,
    .cmd_valid, .cmd, .cmd_ready
  );

  she_core u_core (
    .clk, .rst, .restart, .mode(restart ? pwdata[0] : hash_mode),
    .cmd_valid, .cmd, .cmd_ready,
    .out_valid(core_valid), .out_item(core_item), .out_ready(core_ready)
  );

  she_fifo u_fifo (
    .clk, .rst, .wr_valid(core_valid), .wr_item(core_item), .wr_ready(core_ready),
    .rd_valid, .rd_item(out_item), .rd_ready(pop)
  );

  `SHE_ASSERT(a_idx_range, empty || hash_mode == MODE_512 || out_item.digest_index <= 3'd5,
    "digest index beyond SHA-384 length")
  `SHE_ASSERT_NEXT(a_last_wraps, !empty && pop && out_item.digest_last,
    empty || out_item.digest_index == 3'd0, "digest did not restart at index 0")
  `SHE_ASSERT_NEXT(a_hold_result, !empty && !pop,
    !empty && $stable(out_item), "waiting transaction changed")

endmodule
`default_nettype wire

// File: tb/tb_sha512_hash_engine.sv
module tb_sha512_hash_engine;
  import she_pkg::*;

  class digest_scoreboard;
    logic        mode;
    logic [63:0] chain [8];
    logic [63:0] blk [16];
    logic [63:0] bits_lo, bits_hi;
    logic [6:0]  fill;
    she_out_t    digest_q [$];
    int          errors;

    function new();
      errors = 0;
      mode = MODE_512;
      foreach (blk[i]) blk[i] = '0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i])
        chain[i] = (mode == MODE_384) ? INIT_384[511-64*i -: 64] : INIT_512[511-64*i -: 64];
      bits_lo = '0;
      bits_hi = '0;
      fill = '0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      restart();
    endfunction

    function logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
    endfunction

    function void compress();
      logic [63:0] w [80];
      logic [63:0] v [8];
      logic [63:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++)
        w[i] = (ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
             + (ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
      foreach (v[i]) v[i] = chain[i];
      for (int i = 0; i < 80; i++) begin
        t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
        t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] += v[i];
    endfunction

    function void put_byte(int pos, logic [7:0] b);
      blk[pos/8][63-8*(pos%8) -: 8] = b;
    endfunction

    function void note_input(she_in_t it);
      int cnt, nwords;
      logic [63:0] inc;
      she_out_t r;
      cnt = (it.byte_count > 8) ? 8 : int'(it.byte_count);
      inc = 64'(cnt * 8);
      bits_lo += inc;
      if (bits_lo < inc) bits_hi++;
      for (int k = 0; k < cnt; k++) begin
        put_byte(fill, it.data_word[63-8*k -: 8]);
        fill++;
        if (fill == 0) compress();
      end
      if (!it.last_word) return;
      put_byte(fill, PAD_BYTE);
      for (int q = fill + 1; q < BLOCK_BYTES; q++) put_byte(q, 8'h00);
      if (fill >= PAD_LIMIT) begin
        compress();
        for (int i = 0; i < 14; i++) blk[i] = '0;
      end
      blk[14] = bits_hi;
      blk[15] = bits_lo;
      compress();
      nwords = (mode == MODE_384) ? 6 : 8;
      for (int k = 0; k < nwords; k++) begin
        r.digest_word  = chain[k];
        r.digest_index = 3'(k);
        r.digest_last  = (k == nwords - 1);
        digest_q.push_back(r);
      end
      restart();
    endfunction

    function void check_result(she_out_t got);
      she_out_t exp;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, got);
        errors++;
        return;
      end
      exp = digest_q.pop_front();
      if (got.digest_word !== exp.digest_word) begin
        $display("%0t: digest_word exp %h got %h", $time, exp.digest_word, got.digest_word);
        errors++;
      end
      if (got.digest_index !== exp.digest_index) begin
        $display("%0t: digest_index exp %0d got %0d", $time, exp.digest_index,
                 got.digest_index);
        errors++;
      end
      if (got.digest_last !== exp.digest_last) begin
        $display("%0t: digest_last exp %0d got %0d", $time, exp.digest_last, got.digest_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  she_in_t     in_item = '0;
  logic        full, empty;
  she_out_t    out_item;
  logic        pop = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  digest_scoreboard sb = new();
  int cycles = 0;
  int sent = 0;
  int stall_len = 0;
  bit stall_on = 0;

  sha512_hash_engine DUT (
    .clk(clk), .rst(rst), .push(push), .in_item(in_item), .full(full),
    .empty(empty), .out_item(out_item), .pop(pop), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_result(out_item);
      if (stall_len == 0) begin
        stall_on = !stall_on;
        stall_len = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 40);
      end
      stall_len--;
      pop <= !stall_on || ($urandom_range(0, 3) == 0);
    end
  end

  task automatic write_mode(logic m);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_MODE; pwdata <= {31'd0, m};
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_mode(m);
    pwrite <= 0; penable <= 0;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== m) begin
      $display("%0t: hash_mode read exp %0d got %0d", $time, m, prdata[0]);
      sb.errors++;
    end
    psel <= 0; penable <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [63:0] d, logic [3:0] bc, logic lw);
    she_in_t it;
    it.data_word = d; it.byte_count = bc; it.last_word = lw;
    push <= 1;
    in_item <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
    sent++;
    if ($urandom_range(0, 5) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 0;
    while (sb.digest_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_message();
    int n;
    logic [3:0] bc;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 17);
    for (int i = 0; i < n; i++) begin
      bc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      send_word({$urandom, $urandom}, bc, 1'b0);
    end
    send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty message, odd byte counts, pad spill into extra block
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0);
    send_word(64'h0123_4567_89AB_CDEF, 4'd0, 1'b0);
    send_word(64'h0000_0000_0000_0000, 4'd5, 1'b1);
    for (int i = 0; i < 14; i++) send_word({$urandom, $urandom}, 4'd8, i == 13);
    settle();
    write_mode(MODE_384);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    send_word(64'h8000_0000_0000_0001, 4'd1, 1'b1);
    settle();
    // abandoned message
    for (int i = 0; i < 3; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0);
    settle();
    write_mode(MODE_512);
    while (sent < 85) random_message();
    settle();
    write_mode(MODE_384);
    while (sent < 145) random_message();
    settle();
    write_mode(MODE_512);
    while (sent < 195) random_message();
    settle();
    if (sb.errors == 0 && sb.digest_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
